// ===== sv/cfd_pkg.sv =====
// Shared types and constants for the command frame deframer.
`timescale 1ns / 1ps

package cfd_pkg;

  localparam int unsigned MaxPayloadDflt = 256;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_BODY,
    PH_CHECK
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STAT_GOOD   = 2'd0,
    STAT_CSUM   = 2'd1,
    STAT_LENGTH = 2'd2
  } status_e;

  // Body positions of the header bytes
  localparam logic [15:0] HEADER_BYTES = 16'd15;
  localparam logic [15:0] POS_NET_LO   = 16'd9;
  localparam logic [15:0] POS_NET_HI   = 16'd10;
  localparam logic [15:0] POS_TGT_LO   = 16'd11;
  localparam logic [15:0] POS_TGT_HI   = 16'd12;
  localparam logic [15:0] POS_ID_TYPE  = 16'd13;
  localparam logic [15:0] POS_PORT     = 16'd14;

  // Header field numbers for the assembled fields
  localparam logic [3:0] FIELD_NET_ID  = 4'd9;
  localparam logic [3:0] FIELD_TGT_ID  = 4'd10;
  localparam logic [3:0] FIELD_ID_TYPE = 4'd11;
  localparam logic [3:0] FIELD_PORT    = 4'd12;

  // Configuration register indexes
  localparam logic REG_START_MARKER = 1'b0;

endpackage

// ===== sv/command_frame_deframer.sv =====
// Byte-stream frame parser: start byte, 16-bit length, header, payload, XOR check.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// -------   ---------  -----------------------  --------------------------------------
// in        input      in_valid_i / in_ready_o  rx_byte_i
// out       output     out_valid_o/out_ready_i  item_kind_o .. frame_last_o (7 fields)
// cfg       APB        psel/penable/pwrite      paddr, pwdata, prdata (start marker)
//
// One word is taken per cycle while the result register is free; each word yields
// at most one result word, from the result register loaded at the accept edge.
// The parse state and the result register are the only pipeline: the next
// word is taken whenever the result register is empty or drains this cycle.
// Reset clears the parse state to hunting and empties the result register.
// A stall on the output holds the result word and holds off input.
module command_frame_deframer #(
  parameter int unsigned MAX_PAYLOAD = cfd_pkg::MaxPayloadDflt,
  localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  // byte input
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      rx_byte_i,
  // result output
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      item_kind_o,
  output logic [3:0]      field_select_o,
  output logic [15:0]     field_value_o,
  output logic [7:0]      payload_index_o,
  output logic [1:0]      frame_status_o,
  output logic [CntW-1:0] payload_count_o,
  output logic            frame_last_o,
  // configuration
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import cfd_pkg::*;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PAYLOAD);

  // Parse state
  phase_e          phase_q, phase_d;
  logic [15:0]     body_len_q, body_len_d;
  logic [15:0]     body_pos_q, body_pos_d;
  logic [7:0]      xor_q, xor_d;
  logic [7:0]      low_hold_q, low_hold_d;
  logic [CntW-1:0] emitted_q, emitted_d;
  logic [7:0]      marker_q;

  // Result word built from the current byte
  logic            res_valid;
  kind_e           res_kind;
  logic [3:0]      res_sel;
  logic [15:0]     res_value;
  logic [7:0]      res_index;
  status_e         res_status;
  logic [CntW-1:0] res_count;
  logic            res_last;

  // Result register
  logic            out_valid_q;
  logic [1:0]      kind_q;
  logic [3:0]      sel_q;
  logic [15:0]     value_q;
  logic [7:0]      index_q;
  logic [1:0]      status_q;
  logic [CntW-1:0] count_q;
  logic            last_q;

  logic in_acc;
  logic [15:0] pos_next;
  logic [15:0] pay_pos;
  logic cfg_wr;

  // Take a word whenever the result register is free by the next edge.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign pos_next   = body_pos_q + 16'd1;
  assign pay_pos    = body_pos_q - HEADER_BYTES;

  always_comb begin
    phase_d    = phase_q;
    body_len_d = body_len_q;
    body_pos_d = body_pos_q;
    xor_d      = xor_q;
    low_hold_d = low_hold_q;
    emitted_d  = emitted_q;
    res_valid  = 1'b0;
    res_kind   = KIND_HEADER;
    res_sel    = 4'd0;
    res_value  = 16'd0;
    res_index  = 8'd0;
    res_status = STAT_GOOD;
    res_count  = '0;
    res_last   = 1'b0;
    case (phase_q)
      PH_HUNT: begin
        // Drop everything up to the start marker, then clear the frame state.
        if (rx_byte_i == marker_q) begin
          phase_d    = PH_LEN_LO;
          body_len_d = 16'd0;
          body_pos_d = 16'd0;
          xor_d      = 8'd0;
          low_hold_d = 8'd0;
          emitted_d  = '0;
        end
      end
      PH_LEN_LO: begin
        body_len_d = {8'd0, rx_byte_i};
        phase_d    = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        body_len_d = {rx_byte_i, body_len_q[7:0]};
        if ({rx_byte_i, body_len_q[7:0]} < HEADER_BYTES) begin
          // Too short to hold a header: close the frame at once.
          phase_d    = PH_HUNT;
          res_valid  = 1'b1;
          res_kind   = KIND_END;
          res_status = STAT_LENGTH;
          res_last   = 1'b1;
        end else begin
          body_pos_d = 16'd0;
          phase_d    = PH_BODY;
        end
      end
      PH_BODY: begin
        xor_d = xor_q ^ rx_byte_i;
        if (body_pos_q < POS_NET_LO) begin
          res_valid = 1'b1;
          res_sel   = body_pos_q[3:0];
          res_value = {8'd0, rx_byte_i};
        end else if (body_pos_q == POS_NET_LO || body_pos_q == POS_TGT_LO) begin
          // Low half of a 16-bit field: hold it for the high byte.
          low_hold_d = rx_byte_i;
        end else if (body_pos_q == POS_NET_HI || body_pos_q == POS_TGT_HI) begin
          res_valid = 1'b1;
          res_sel   = (body_pos_q == POS_NET_HI) ? FIELD_NET_ID : FIELD_TGT_ID;
          res_value = {rx_byte_i, low_hold_q};
        end else if (body_pos_q == POS_ID_TYPE || body_pos_q == POS_PORT) begin
          res_valid = 1'b1;
          res_sel   = (body_pos_q == POS_ID_TYPE) ? FIELD_ID_TYPE : FIELD_PORT;
          res_value = {8'd0, rx_byte_i};
        end else if (emitted_q < MaxCnt) begin
          res_valid = 1'b1;
          res_kind  = KIND_PAYLOAD;
          res_value = {8'd0, rx_byte_i};
          res_index = pay_pos[7:0];
          emitted_d = emitted_q + 1'b1;
        end
        // Bytes past the payload limit only feed the checksum.
        body_pos_d = pos_next;
        if (pos_next >= body_len_q) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        phase_d    = PH_HUNT;
        res_valid  = 1'b1;
        res_kind   = KIND_END;
        res_status = (rx_byte_i == xor_q) ? STAT_GOOD : STAT_CSUM;
        res_count  = emitted_q;
        res_last   = 1'b1;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  // Advance the parse state on each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      body_len_q <= 16'd0;
      body_pos_q <= 16'd0;
      xor_q      <= 8'd0;
      low_hold_q <= 8'd0;
      emitted_q  <= '0;
    end else if (in_acc) begin
      phase_q    <= phase_d;
      body_len_q <= body_len_d;
      body_pos_q <= body_pos_d;
      xor_q      <= xor_d;
      low_hold_q <= low_hold_d;
      emitted_q  <= emitted_d;
    end
  end

  // Result register: load on accept, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_acc && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && res_valid) begin
      kind_q   <= res_kind;
      sel_q    <= res_sel;
      value_q  <= res_value;
      index_q  <= res_index;
      status_q <= res_status;
      count_q  <= res_count;
      last_q   <= res_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign item_kind_o     = kind_q;
  assign field_select_o  = sel_q;
  assign field_value_o   = value_q;
  assign payload_index_o = index_q;
  assign frame_status_o  = status_q;
  assign payload_count_o = count_q;
  assign frame_last_o    = last_q;

  // Configuration: one register, the start marker, at word 0.
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_START_MARKER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= 8'd0;
    end else if (cfg_wr) begin
      marker_q <= pwdata[7:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_START_MARKER) ? {24'd0, marker_q} : 32'd0;

endmodule

// ===== sv/cfd_checker.sv =====
// Port-level checker for the command frame deframer, bound to the top level.
`timescale 1ns / 1ps

module cfd_checker #(
  parameter int unsigned MAX_PAYLOAD = cfd_pkg::MaxPayloadDflt,
  localparam int unsigned CntW = $clog2(MAX_PAYLOAD + 1)
) (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [1:0]      item_kind_o,
  input logic [3:0]      field_select_o,
  input logic [15:0]     field_value_o,
  input logic [7:0]      payload_index_o,
  input logic [1:0]      frame_status_o,
  input logic [CntW-1:0] payload_count_o,
  input logic            frame_last_o
);
  import cfd_pkg::*;

  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PAYLOAD);

  // A stalled result word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(item_kind_o)
      && $stable(field_value_o) && $stable(frame_last_o))
    else $error("stalled result word changed");

  // An empty result register never holds off input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // Only end words close a frame, and they carry a count within the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_last_o |-> item_kind_o == KIND_END && payload_count_o <= MaxCnt)
    else $error("bad end word");

  // Non-end words carry no status, count or last flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o != KIND_END |->
      !frame_last_o && frame_status_o == STAT_GOOD && payload_count_o == '0)
    else $error("status on a data word");

  // Header words name a real field.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && item_kind_o == KIND_HEADER |->
      field_select_o <= FIELD_PORT && payload_index_o == 8'd0)
    else $error("bad header word");

endmodule

bind command_frame_deframer cfd_checker #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_cfd_checker (.*);
